/* hw/rtl/sfd_pkg.sv */
// Shared types and constants of the sensor frame deframer.
// Holds the parser phase and event codes, register indexes and reset values.
// Depends on nothing; imported by sensor_frame_deframer_core.
package sfd_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_VER   = 3'd2,
    PH_DATA  = 3'd3,
    PH_CHK1  = 3'd4,
    PH_CHK2  = 3'd5,
    PH_END   = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_START  = 3'd1,
    EV_GOOD   = 3'd2,
    EV_BADVER = 3'd3,
    EV_ZERO   = 3'd4,
    EV_BADEND = 3'd5
  } event_e;

  typedef enum logic [1:0] {
    REG_START_MARKER  = 2'd0,
    REG_VERSION_VALUE = 2'd1,
    REG_END_MARKER    = 2'd2,
    REG_RECORD_LENGTH = 2'd3
  } reg_idx_e;

  localparam logic [7:0] START_MARKER_RST  = 8'hAA;
  localparam logic [7:0] VERSION_VALUE_RST = 8'h01;
  localparam logic [7:0] END_MARKER_RST    = 8'h55;
  localparam logic [3:0] RECORD_LENGTH_RST = 4'd5;

endpackage

/* hw/rtl/sensor_frame_deframer_core.sv */
// Sensor frame deframer: parser state, statistics counters and result register.
// Depends on sfd_pkg for phase and event codes and register reset values.
//
// Usage:
// Received bytes enter on the rx channel (rx_valid_i / rx_ready_o / rx_byte_i).
// Each accepted byte yields exactly one result on the res channel: an event
// code, the running frame length, the record count from the frame header, the
// wrapping byte, good frame and bad frame counters, the largest record count
// seen, and the parser phase after that byte.
// The result of a byte is registered and is valid in the cycle after the byte
// is accepted. Throughput is one byte per cycle while the receiver takes each
// result, set by the single update of the parser registers, which all sit behind one level of logic.
// The result register acts as the output stage: a new byte is taken whenever
// the register is empty or its result is taken in the same cycle. When the
// receiver stalls, the pending result holds and rx_ready_o drops until it
// leaves, so nothing is lost or repeated.
// The APB port writes start_marker, version_value, end_marker and
// record_length at byte addresses 0, 4, 8 and 12; write only while idle.
// Reset clears the parser to idle, zeroes all counters, restores the register
// defaults and empties the result register.
module sensor_frame_deframer_core #(
  parameter int STAT_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Byte input channel.
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  // Result channel.
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic [2:0]  event_res_o,
  output logic [11:0] frame_length_o,
  output logic [7:0]  record_count_o,
  output logic [31:0] bytes_seen_o,
  output logic [31:0] good_frames_o,
  output logic [31:0] bad_frames_o,
  output logic [7:0]  largest_count_o,
  output logic [2:0]  parser_phase_o,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sfd_pkg::*;

  // Configuration registers.
  logic [7:0] start_marker_q, version_value_q, end_marker_q;
  logic [3:0] record_length_q;
  logic       cfg_wr;
  reg_idx_e   cfg_idx;

  // Parser state.
  phase_e                  phase_q, phase_d;
  logic [7:0]              header_count_q, header_count_d;
  logic [7:0]              record_index_q, record_index_d;
  logic [3:0]              byte_index_q, byte_index_d;
  logic [11:0]             length_q, length_d;
  logic [STAT_WIDTH-1:0]   bytes_q, bytes_d;
  logic [STAT_WIDTH-1:0]   good_q, good_d;
  logic [STAT_WIDTH-1:0]   bad_q, bad_d;
  logic [7:0]              max_count_q, max_count_d;
  event_e                  event_d;

  // Incremented forms used by the next-state logic.
  logic [3:0]              byte_index_inc;
  logic [7:0]              record_index_inc;
  logic [63:0]             bytes_ext, good_ext, bad_ext;

  logic rx_accept;
  logic res_valid_q;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (cfg_idx)
      REG_START_MARKER:  prdata = {24'd0, start_marker_q};
      REG_VERSION_VALUE: prdata = {24'd0, version_value_q};
      REG_END_MARKER:    prdata = {24'd0, end_marker_q};
      REG_RECORD_LENGTH: prdata = {28'd0, record_length_q};
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q  <= START_MARKER_RST;
      version_value_q <= VERSION_VALUE_RST;
      end_marker_q    <= END_MARKER_RST;
      record_length_q <= RECORD_LENGTH_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_START_MARKER:  start_marker_q  <= pwdata[7:0];
        REG_VERSION_VALUE: version_value_q <= pwdata[7:0];
        REG_END_MARKER:    end_marker_q    <= pwdata[7:0];
        REG_RECORD_LENGTH: record_length_q <= pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  // A byte is taken when the result register is empty or drains this cycle.
  assign rx_ready_o = !res_valid_q || res_ready_i;
  assign rx_accept  = rx_valid_i && rx_ready_o;

  assign byte_index_inc   = byte_index_q + 4'd1;
  assign record_index_inc = record_index_q + 8'd1;

  // Next state for one byte. Every frame byte after the start marker adds one
  // to the frame length; the start marker itself restarts it at one.
  always_comb begin
    phase_d        = phase_q;
    header_count_d = header_count_q;
    record_index_d = record_index_q;
    byte_index_d   = byte_index_q;
    length_d       = length_q;
    bytes_d        = bytes_q + STAT_WIDTH'(1);
    good_d         = good_q;
    bad_d          = bad_q;
    max_count_d    = max_count_q;
    event_d        = EV_NONE;

    if (phase_q != PH_IDLE) begin
      length_d = length_q + 12'd1;
    end

    case (phase_q)
      PH_IDLE: begin
        if (rx_byte_i == start_marker_q) begin
          phase_d  = PH_START;
          length_d = 12'd1;
          event_d  = EV_START;
        end
      end
      PH_START: begin
        if (rx_byte_i == version_value_q) begin
          phase_d = PH_VER;
        end else begin
          phase_d = PH_IDLE;
          bad_d   = bad_q + STAT_WIDTH'(1);
          event_d = EV_BADVER;
        end
      end
      PH_VER: begin
        header_count_d = rx_byte_i;
        record_index_d = 8'd0;
        byte_index_d   = 4'd0;
        if (rx_byte_i > max_count_q) begin
          max_count_d = rx_byte_i;
        end
        if (rx_byte_i == 8'd0) begin
          phase_d = PH_IDLE;
          bad_d   = bad_q + STAT_WIDTH'(1);
          event_d = EV_ZERO;
        end else begin
          phase_d = PH_DATA;
        end
      end
      PH_DATA: begin
        // A record length of zero lets the byte index wrap, giving 16 bytes.
        byte_index_d = byte_index_inc;
        if (byte_index_inc == record_length_q) begin
          byte_index_d   = 4'd0;
          record_index_d = record_index_inc;
          if (record_index_inc >= header_count_q) begin
            phase_d = PH_CHK1;
          end
        end
      end
      PH_CHK1: begin
        phase_d = PH_CHK2;
      end
      PH_CHK2: begin
        phase_d = PH_END;
      end
      default: begin
        // The end marker is expected here.
        if (rx_byte_i == end_marker_q) begin
          good_d  = good_q + STAT_WIDTH'(1);
          event_d = EV_GOOD;
        end else begin
          bad_d   = bad_q + STAT_WIDTH'(1);
          event_d = EV_BADEND;
        end
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      header_count_q <= 8'd0;
      record_index_q <= 8'd0;
      byte_index_q   <= 4'd0;
      length_q       <= 12'd0;
      bytes_q        <= '0;
      good_q         <= '0;
      bad_q          <= '0;
      max_count_q    <= 8'd0;
    end else if (rx_accept) begin
      phase_q        <= phase_d;
      header_count_q <= header_count_d;
      record_index_q <= record_index_d;
      byte_index_q   <= byte_index_d;
      length_q       <= length_d;
      bytes_q        <= bytes_d;
      good_q         <= good_d;
      bad_q          <= bad_d;
      max_count_q    <= max_count_d;
    end
  end

  // The counters may be narrower or wider than the 32-bit result fields.
  assign bytes_ext = 64'(bytes_d);
  assign good_ext  = 64'(good_d);
  assign bad_ext   = 64'(bad_d);

  // Result register: valid is control state, the payload needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (rx_accept) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_accept) begin
      event_res_o     <= event_d;
      frame_length_o  <= length_d;
      record_count_o  <= header_count_d;
      bytes_seen_o    <= bytes_ext[31:0];
      good_frames_o   <= good_ext[31:0];
      bad_frames_o    <= bad_ext[31:0];
      largest_count_o <= max_count_d;
      parser_phase_o  <= phase_d;
    end
  end

  assign res_valid_o = res_valid_q;

`ifndef SYNTHESIS
  // An accepted byte always leaves a result in the register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_accept |=> res_valid_o)
    else $error("accepted byte left no result");

  // A start marker seen while idle opens a frame of length one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_accept && phase_q == PH_IDLE && rx_byte_i == start_marker_q) |=>
      (event_res_o == EV_START && parser_phase_o == PH_START && frame_length_o == 12'd1))
    else $error("start marker did not open a frame");

  // Every frame-ending event returns the parser to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (event_res_o == EV_GOOD || event_res_o == EV_BADEND ||
                     event_res_o == EV_BADVER || event_res_o == EV_ZERO)) |->
      parser_phase_o == PH_IDLE)
    else $error("frame ended but parser not idle");

  // The data phase is only reached with a nonzero record count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> header_count_q != 8'd0)
    else $error("data phase with zero record count");

  // Without an accepted byte the byte counter holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_accept |=> $stable(bytes_q))
    else $error("byte counter moved without a byte");
`endif

endmodule
